/* rtl/core/bpc_pkg.sv */
// ----------------------------------------------------------------------------
// bpc_pkg
// shared codes and types for the bipartite two-coloring block
// ----------------------------------------------------------------------------
package bpc_pkg;

  // operation codes of an input word
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_CHECK = 2'd2;

  // side codes
  localparam logic [1:0] SIDE_FIRST = 2'd0;
  localparam logic [1:0] SIDE_NONE  = 2'd2;

  // vertex_count after reset
  localparam logic [6:0] VCOUNT_RESET = 7'd64;

  // adjacency store control
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } adj_ctl_t;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_ADD_RD    = 12'b0000_0000_0010,
    ST_ADD_WR    = 12'b0000_0000_0100,
    ST_INIT      = 12'b0000_0000_1000,
    ST_LOAD      = 12'b0000_0001_0000,
    ST_ROW_WAIT  = 12'b0000_0010_0000,
    ST_SCAN      = 12'b0000_0100_0000,
    ST_SIDE_WAIT = 12'b0000_1000_0000,
    ST_POP_WAIT  = 12'b0001_0000_0000,
    ST_EMIT_RD   = 12'b0010_0000_0000,
    ST_EMIT_LD   = 12'b0100_0000_0000,
    ST_EMIT_HOLD = 12'b1000_0000_0000
  } state_t;

endpackage

/* rtl/core/bpc_ram.sv */
// ----------------------------------------------------------------------------
// bpc_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/bpc_adj.sv */
// ----------------------------------------------------------------------------
// bpc_adj
// adjacency bit matrix, one row per vertex, with per-row valid bits
// ----------------------------------------------------------------------------
module bpc_adj import bpc_pkg::*; #(
  parameter int ROWS = 64
) (
  input  logic                    clk,
  input  logic                    rst,
  input  adj_ctl_t                ctl,
  input  logic [$clog2(ROWS)-1:0] rd_addr,
  input  logic [$clog2(ROWS)-1:0] wr_addr,
  input  logic [ROWS-1:0]         wr_data,
  output logic [ROWS-1:0]         row
);

  logic [ROWS-1:0] row_valid;
  logic            rd_valid;
  logic [ROWS-1:0] ram_q;

  // invalid rows read as empty
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      row_valid <= '0;
    end else if (ctl.wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
    if (ctl.rd_en) begin
      rd_valid <= row_valid[rd_addr];
    end
  end

  bpc_ram #(.WIDTH(ROWS), .DEPTH(ROWS)) u_ram (
    .clk     (clk),
    .wr_en   (ctl.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (ctl.rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  assign row = rd_valid ? ram_q : '0;

endmodule

/* rtl/core/bipartite_two_coloring.sv */
// ----------------------------------------------------------------------------
// bipartite_two_coloring
// operation: clear empties the edges; add edge sets the bit in both rows;
//   check resets the sides, walks from vertex 1 testing the edge bits of each
//   reached row, then emits one result word per vertex in use, held under output stall
// throughput: one input word at a time; the walk tests one adjacency bit
//   per cycle while no edge bit is met, which sets the check time
// reset: synchronous; edges cleared through row valid bits, vertex_count = 64
// ----------------------------------------------------------------------------
module bipartite_two_coloring import bpc_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: vertex_count
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,
  // command words
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // operation[1:0], vertex_a[8:2], vertex_b[15:9]
  // result words
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // vertex_id[6:0], side[8:7], zero fill
  output logic [0:0]  m_tuser,   // is_bipartite[0]
  output logic        m_tlast
);

  localparam int IW = $clog2(MAX_VERTICES);       // vertex index width
  localparam int CW = $clog2(MAX_VERTICES + 1);   // count width
  localparam int SW = CW + IW;                    // stack entry width
  localparam logic [6:0] MAX_V7 = 7'(MAX_VERTICES);

  state_t state;

  // configuration register
  logic [6:0] vertex_count;
  logic [CW-1:0] n_clamped;

  // command word fields
  logic [1:0] in_op;
  logic [6:0] in_a;
  logic [6:0] in_b;
  logic       in_accept;
  logic       a_ok;
  logic       b_ok;

  // edge insert
  logic [IW-1:0] ea;
  logic [IW-1:0] eb;
  logic          second;
  logic [MAX_VERTICES-1:0] edge_bit;

  // walk state; the top of stack lives in registers
  logic [CW-1:0] n;
  logic [CW-1:0] idx;
  logic [CW-1:0] sp;
  logic [IW-1:0] top_v;
  logic [CW-1:0] top_n;
  logic [MAX_VERTICES-1:0] cur_row;
  logic [1:0] cur_side;
  logic conflict;
  logic scan_end;
  logic scan_hit;

  // adjacency store
  adj_ctl_t adj_ctl;
  logic [IW-1:0] adj_rd_addr;
  logic [IW-1:0] adj_wr_addr;
  logic [MAX_VERTICES-1:0] adj_wr_data;
  logic [MAX_VERTICES-1:0] adj_row;

  // side memory
  logic          side_we;
  logic [IW-1:0] side_waddr;
  logic [1:0]    side_wdata;
  logic          side_re;
  logic [IW-1:0] side_raddr;
  logic [1:0]    side_q;

  // stack memory, entry = {next neighbor, vertex}
  logic          stk_we;
  logic [IW-1:0] stk_waddr;
  logic [SW-1:0] stk_wdata;
  logic          stk_re;
  logic [IW-1:0] stk_raddr;
  logic [SW-1:0] stk_q;
  logic [IW-1:0] stk_v;
  logic [CW-1:0] stk_n;

  assign in_op     = s_tdata[1:0];
  assign in_a      = s_tdata[8:2];
  assign in_b      = s_tdata[15:9];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign a_ok      = (in_a != 7'd0) && (in_a <= MAX_V7);
  assign b_ok      = (in_b != 7'd0) && (in_b <= MAX_V7);

  assign edge_bit = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << eb;

  assign scan_end = (top_n >= n);
  assign scan_hit = cur_row[top_n[IW-1:0]];

  assign stk_v = stk_q[IW-1:0];
  assign stk_n = stk_q[SW-1:IW];

  // zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (vertex_count == 7'd0) begin
      n_clamped = CW'(1);
    end else if (vertex_count > MAX_V7) begin
      n_clamped = CW'(MAX_VERTICES);
    end else begin
      n_clamped = CW'(vertex_count);
    end
  end

  // memory port control
  always_comb begin
    adj_ctl       = '0;
    adj_ctl.clear = in_accept && (in_op == OP_CLEAR);
    adj_rd_addr   = top_v;
    adj_wr_addr   = ea;
    adj_wr_data   = adj_row | edge_bit;
    side_we       = 1'b0;
    side_waddr    = top_n[IW-1:0];
    side_wdata    = {1'b0, ~cur_side[0]};
    side_re       = 1'b0;
    side_raddr    = top_v;
    stk_we        = 1'b0;
    stk_waddr     = IW'(sp - CW'(1));
    stk_wdata     = {CW'(top_n + CW'(1)), top_v};
    stk_re        = 1'b0;
    stk_raddr     = IW'(sp - CW'(2));
    case (state)
      ST_ADD_RD: begin
        adj_ctl.rd_en = 1'b1;
        adj_rd_addr   = ea;
      end
      ST_ADD_WR: begin
        adj_ctl.wr_en = 1'b1;
      end
      ST_INIT: begin
        // vertex 1 starts the walk on the first side
        side_we    = 1'b1;
        side_waddr = idx[IW-1:0];
        side_wdata = (idx == '0) ? SIDE_FIRST : SIDE_NONE;
      end
      ST_LOAD: begin
        adj_ctl.rd_en = 1'b1;
        side_re       = 1'b1;
      end
      ST_SCAN: begin
        if (scan_end) begin
          stk_re = (sp > CW'(1));
        end else if (scan_hit) begin
          side_re    = 1'b1;
          side_raddr = top_n[IW-1:0];
        end
      end
      ST_SIDE_WAIT: begin
        // uncolored neighbor: color it and push the current vertex
        if (side_q == SIDE_NONE) begin
          side_we = 1'b1;
          stk_we  = 1'b1;
        end
      end
      ST_POP_WAIT: begin
        adj_ctl.rd_en = 1'b1;
        adj_rd_addr   = stk_v;
        side_re       = 1'b1;
        side_raddr    = stk_v;
      end
      ST_EMIT_RD: begin
        side_re    = 1'b1;
        side_raddr = idx[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      vertex_count <= VCOUNT_RESET;
      m_tvalid     <= 1'b0;
      sp           <= '0;
      conflict     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (in_accept) begin
            case (in_op)
              OP_ADD: begin
                if (a_ok && b_ok) begin
                  ea     <= IW'(in_a - 7'd1);
                  eb     <= IW'(in_b - 7'd1);
                  second <= 1'b0;
                  state  <= ST_ADD_RD;
                end
              end
              OP_CHECK: begin
                n     <= n_clamped;
                idx   <= '0;
                state <= ST_INIT;
              end
              default: begin
                // clear is done by the store, unused code does nothing
              end
            endcase
          end
        end
        ST_ADD_RD: begin
          state <= ST_ADD_WR;
        end
        ST_ADD_WR: begin
          // second pass sets the mirrored bit
          if (!second) begin
            ea     <= eb;
            eb     <= ea;
            second <= 1'b1;
            state  <= ST_ADD_RD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_INIT: begin
          if (idx == n - CW'(1)) begin
            top_v    <= '0;
            top_n    <= '0;
            sp       <= CW'(1);
            conflict <= 1'b0;
            state    <= ST_LOAD;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_LOAD: begin
          state <= ST_ROW_WAIT;
        end
        ST_ROW_WAIT: begin
          cur_row  <= adj_row;
          cur_side <= side_q;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_end) begin
            sp <= sp - CW'(1);
            if (sp == CW'(1)) begin
              idx   <= '0;
              state <= ST_EMIT_RD;
            end else begin
              state <= ST_POP_WAIT;
            end
          end else if (scan_hit) begin
            state <= ST_SIDE_WAIT;
          end else begin
            top_n <= top_n + CW'(1);
          end
        end
        ST_SIDE_WAIT: begin
          if (side_q == SIDE_NONE) begin
            top_v <= top_n[IW-1:0];
            top_n <= '0;
            sp    <= sp + CW'(1);
            state <= ST_LOAD;
          end else begin
            if (side_q == cur_side) begin
              conflict <= 1'b1;
            end
            top_n <= top_n + CW'(1);
            state <= ST_SCAN;
          end
        end
        ST_POP_WAIT: begin
          top_v <= stk_v;
          top_n <= stk_n;
          state <= ST_ROW_WAIT;
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          m_tdata    <= {7'd0, side_q, 7'(idx) + 7'd1};
          m_tuser[0] <= ~conflict;
          m_tlast    <= (idx == n - CW'(1));
          m_tvalid   <= 1'b1;
          state      <= ST_EMIT_HOLD;
        end
        ST_EMIT_HOLD: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            if (m_tlast) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // adjacency matrix
  bpc_adj #(.ROWS(MAX_VERTICES)) u_adj (
    .clk     (clk),
    .rst     (rst),
    .ctl     (adj_ctl),
    .rd_addr (adj_rd_addr),
    .wr_addr (adj_wr_addr),
    .wr_data (adj_wr_data),
    .row     (adj_row)
  );

  // vertex sides
  bpc_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_side_ram (
    .clk     (clk),
    .wr_en   (side_we),
    .wr_addr (side_waddr),
    .wr_data (side_wdata),
    .rd_en   (side_re),
    .rd_addr (side_raddr),
    .rd_data (side_q)
  );

  // walk stack, entries below the top
  bpc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack_ram (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_en   (stk_re),
    .rd_addr (stk_raddr),
    .rd_data (stk_q)
  );

`ifndef SYNTHESIS
  // a result word is shown only while the emit sequence holds it
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (state == ST_EMIT_HOLD))
    else $error("result valid outside emit hold");

  // stack depth stays within the vertex count during the walk
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> ((sp != '0) && (sp <= n)))
    else $error("walk stack depth out of range");

  // the final word reports the last vertex in use
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[6:0] == 7'(n)))
    else $error("last word carries wrong vertex");

  // a pushed neighbor is always loaded next
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SIDE_WAIT && side_q == SIDE_NONE) |=> (state == ST_LOAD))
    else $error("push not followed by row load");
`endif

endmodule
